// ----- hdl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte functions for the AES-128 block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned NUM_ROUNDS = 10;
	localparam int unsigned KEY_WORDS = 4 * (NUM_ROUNDS + 1);
	localparam int unsigned RND_W = 4;
	localparam int unsigned KW_IDX_W = 6;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;
	typedef logic [127:0] block_t;

	typedef struct packed {
		logic load;
		logic decrypt;
		logic last_round;
		logic key_start;
		logic key_step;
		logic [RND_W-1:0] rnd;
		logic [KW_IDX_W-1:0] key_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic key_last;
	} ctrl_sts_t;

	localparam byte_t SBOX [256] = '{
	8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
	8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
	8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
	8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
	8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
	8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
	8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
	8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
	8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
	8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
	8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
	8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
	8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
	8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
	8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
	8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam byte_t INV_SBOX [256] = '{
	8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
	8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
	8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
	8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
	8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
	8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
	8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
	8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
	8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
	8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
	8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
	8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
	8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
	8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
	8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic word_t mix_col(input word_t w, input logic inv);
		byte_t a0, a1, a2, a3;
		byte_t b0, b1, b2, b3;
		byte_t u, v;
		a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
		// The inverse is a premultiply by {05,00,04,00} followed by the forward mix.
		if (inv) begin
			u = xtime(xtime(a0 ^ a2));
			v = xtime(xtime(a1 ^ a3));
			a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
		end
		b0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
		b1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
		b2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
		b3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		return {b0, b1, b2, b3};
	endfunction

endpackage

// ----- hdl/aes_ctrl.sv -----
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion and the ten cipher rounds, and owns the handshake.
// ----------------------------------------------------------------------------
module aes_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic in_cmd,
	output logic out_valid,
	input  logic out_stall,
	input  logic cfg_start,
	input  aes_pkg::ctrl_sts_t sts,
	output aes_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic decrypt_q;
	logic [aes_pkg::RND_W-1:0] cnt_q;
	logic [aes_pkg::KW_IDX_W-1:0] kidx_q;
	logic accept;
	logic last;
	logic in_dec;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall) || cfg_start;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign last = (cnt_q == aes_pkg::RND_W'(aes_pkg::NUM_ROUNDS));
	assign in_dec = (in_cmd == aes_pkg::CMD_DECRYPT);

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.decrypt = accept ? in_dec : decrypt_q;
		cmd.key_start = cfg_start;
		cmd.key_step = (state_q == ST_EXPAND);
		cmd.key_idx = kidx_q;
		cmd.last_round = (state_q == ST_ROUND) && last;
		if (accept) begin
			cmd.rnd = in_dec ? aes_pkg::RND_W'(aes_pkg::NUM_ROUNDS) : '0;
		end else begin
			cmd.rnd = decrypt_q ? aes_pkg::RND_W'(aes_pkg::NUM_ROUNDS) - cnt_q : cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			decrypt_q <= 1'b0;
			cnt_q <= '0;
			kidx_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_start) begin
						state_q <= ST_EXPAND;
						kidx_q <= aes_pkg::KW_IDX_W'(4);
					end else if (accept) begin
						state_q <= ST_ROUND;
						decrypt_q <= in_dec;
						cnt_q <= aes_pkg::RND_W'(1);
					end
				end
				ST_EXPAND: begin
					if (cfg_start) begin
						kidx_q <= aes_pkg::KW_IDX_W'(4);
					end else if (sts.key_last) begin
						state_q <= ST_IDLE;
					end else begin
						kidx_q <= kidx_q + aes_pkg::KW_IDX_W'(1);
					end
				end
				ST_ROUND: begin
					if (last) begin
						state_q <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + aes_pkg::RND_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/aes_datapath.sv -----
// ----------------------------------------------------------------------------
// AES datapath
// Key schedule memory, one shared round unit and the result register.
// ----------------------------------------------------------------------------
module aes_datapath (
	input  logic clk,
	input  aes_pkg::ctrl_cmd_t cmd,
	output aes_pkg::ctrl_sts_t sts,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	aes_pkg::block_t rk_q [aes_pkg::NUM_ROUNDS + 1];
	aes_pkg::word_t w1_q, w2_q, w3_q, w4_q;
	aes_pkg::byte_t rcon_q;
	aes_pkg::block_t state_q;
	aes_pkg::block_t res_q;
	aes_pkg::block_t din;
	aes_pkg::block_t rkey;
	aes_pkg::block_t sb, sr, mc, nxt;
	aes_pkg::word_t t, nw;

	// Expansion keeps the last four words in a sliding window.
	always_comb begin
		t = w4_q;
		if (cmd.key_idx[1:0] == 2'd0) begin
			t = {aes_pkg::SBOX[w4_q[23:16]], aes_pkg::SBOX[w4_q[15:8]],
				aes_pkg::SBOX[w4_q[7:0]], aes_pkg::SBOX[w4_q[31:24]]} ^ {rcon_q, 24'h0};
		end
		nw = w1_q ^ t;
	end

	assign sts.key_last = (cmd.key_idx == aes_pkg::KW_IDX_W'(aes_pkg::KEY_WORDS - 1));

	always_ff @(posedge clk) begin
		if (cmd.key_start) begin
			{w1_q, w2_q, w3_q, w4_q} <= {key_high, key_low};
			rk_q[0] <= {key_high, key_low};
			rcon_q <= 8'h01;
		end else if (cmd.key_step) begin
			rk_q[cmd.key_idx[5:2]][127-32*cmd.key_idx[1:0] -: 32] <= nw;
			{w1_q, w2_q, w3_q, w4_q} <= {w2_q, w3_q, w4_q, nw};
			if (cmd.key_idx[1:0] == 2'd0) begin
				rcon_q <= aes_pkg::xtime(rcon_q);
			end
		end
	end

	assign rkey = rk_q[cmd.rnd];
	assign din = {block_high, block_low};

	// Byte n sits at bits 127-8n; row n%4, column n/4.
	always_comb begin
		for (int n = 0; n < 16; n++) begin
			sb[127-8*n -: 8] = cmd.decrypt ? aes_pkg::INV_SBOX[state_q[127-8*n -: 8]]
				: aes_pkg::SBOX[state_q[127-8*n -: 8]];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (cmd.decrypt) begin
					sr[127-8*(r+4*((c+r)%4)) -: 8] = sb[127-8*(r+4*c) -: 8];
				end else begin
					sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
				end
			end
		end
		if (cmd.decrypt) begin
			// Decrypt round: inverse shift and sub, add key, inverse mix (no mix in the last round).
			for (int c = 0; c < 4; c++) begin
				mc[127-32*c -: 32] = aes_pkg::mix_col(sr[127-32*c -: 32] ^ rkey[127-32*c -: 32],
					1'b1);
			end
			nxt = cmd.last_round ? (sr ^ rkey) : mc;
		end else begin
			for (int c = 0; c < 4; c++) begin
				mc[127-32*c -: 32] = aes_pkg::mix_col(sr[127-32*c -: 32], 1'b0);
			end
			nxt = (cmd.last_round ? sr : mc) ^ rkey;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= din ^ rkey;
		end else begin
			state_q <= nxt;
		end
		if (cmd.last_round) begin
			res_q <= nxt;
		end
	end

	assign result_high = res_q[127:64];
	assign result_low = res_q[63:0];

endmodule

// ----- hdl/aes128_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher top level
// Encrypts or decrypts one 128-bit block per transaction with a stored key.
// ----------------------------------------------------------------------------
// Usage:
// Write the key through the configuration port (index 0 upper half, index 1
// lower half). Each write starts a key expansion of 40 round-key words, one
// per cycle; input is stalled in the write cycle and during expansion.
// Write the key only while no transaction is in flight.
// An input transaction carries cmd (0 encrypt, 1 decrypt) and a block. It is
// taken when in_valid is high and in_stall is low. The initial key addition
// happens at accept, then the shared round unit does one round per cycle for
// the ten rounds. A new block is not taken until the previous one has left
// the round unit. The result register holds its value while out_stall is
// high, and in_stall stays high until the waiting result is taken.
// Reset clears the controller and output valid; the key store is undefined
// until a key register is written.
// ----------------------------------------------------------------------------
module aes128_block_cipher_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic out_valid,
	input  logic out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [63:0] kh, kl;
	logic cfg_start;
	aes_pkg::ctrl_cmd_t ctl;
	aes_pkg::ctrl_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == aes_pkg::REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end else begin
				key_low_q <= cfg_data;
			end
		end
	end

	assign cfg_start = cfg_we;
	assign kh = (cfg_we && cfg_index == aes_pkg::REG_KEY_HIGH) ? cfg_data : key_high_q;
	assign kl = (cfg_we && cfg_index == aes_pkg::REG_KEY_LOW) ? cfg_data : key_low_q;

	aes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall),
		.cfg_start(cfg_start), .sts(sts), .cmd(ctl)
	);

	aes_datapath u_dp (
		.clk(clk), .cmd(ctl), .sts(sts),
		.key_high(kh), .key_low(kl),
		.block_high(block_high), .block_low(block_low),
		.result_high(result_high), .result_low(result_low)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.key_step |-> !(in_valid && !in_stall)) else $error("accept during expansion");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(result_high) && $stable(result_low))
		else $error("result changed while stalled");
	a_one_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.last_round |=> out_valid) else $error("finished round without result");

endmodule
